>>> rtl/wvvu_pkg.sv
// ----------------------------------------------------------------------------
// wvvu_pkg
// Types, widths and command codes shared by the per-slot running mean and
// variance unit.
// ----------------------------------------------------------------------------
package wvvu_pkg;

    // field widths
    localparam int SLOT_W   = 10;
    localparam int SAMPLE_W = 32;
    localparam int FRAC_EXT = 16;
    localparam int MEAN_W   = 48;
    localparam int VAR_W    = 64;
    localparam int COUNT_W  = 32;

    // arithmetic unit widths
    localparam int DIV_W       = 98;
    localparam int DIV_STEPS_W = 6;
    localparam int MUL_W       = 64;
    localparam int PROD_W      = 128;
    localparam int T_W         = 65;
    localparam int NUM_W       = 97;

    // dividend lengths for each division, rounded up to even bit counts
    localparam int SLOT_DIV_BITS = 10;
    localparam int MEAN_DIV_BITS = 50;
    localparam int T_DIV_BITS    = 96;
    localparam int VAR_DIV_BITS  = 98;

    // vector count saturates here so that n fits in COUNT_W bits
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFE;

    typedef logic        [SLOT_W-1:0]   t_slot;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MEAN_W-1:0]   t_mean;
    typedef logic        [VAR_W-1:0]    t_var;
    typedef logic        [COUNT_W-1:0]  t_count;

    // controller states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_DIFF,
        S_MDIV,
        S_MWAIT,
        S_ERR,
        S_SQ,
        S_SQW,
        S_SNW,
        S_TDW,
        S_VMW,
        S_NUM,
        S_VDIV,
        S_VDW,
        S_VKEEP,
        S_WRITE,
        S_OUT
    } t_state;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_READ,
        OP_DIFF,
        OP_MDIV,
        OP_MNEW,
        OP_ERR,
        OP_SQ,
        OP_SN,
        OP_TDIV,
        OP_VMUL,
        OP_NUM,
        OP_VDIV,
        OP_VNEW,
        OP_VKEEP,
        OP_WRITE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic mul_done;
        logic n_is_one;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/wvvu_if.sv
// ----------------------------------------------------------------------------
// wvvu_in_if / wvvu_out_if
// Valid/ready channels for samples into and results out of the unit.
// ----------------------------------------------------------------------------
interface wvvu_in_if;
    logic              valid;
    logic              ready;
    wvvu_pkg::t_slot   slot;
    wvvu_pkg::t_sample sample;
    logic              vector_end;

    modport source (output valid, output slot, output sample, output vector_end,
                    input ready);
    modport sink   (input valid, input slot, input sample, input vector_end,
                    output ready);
endinterface

interface wvvu_out_if;
    logic             valid;
    logic             ready;
    wvvu_pkg::t_mean  new_mean;
    wvvu_pkg::t_var   new_variance;
    wvvu_pkg::t_count samples_seen;

    modport source (output valid, output new_mean, output new_variance,
                    output samples_seen, input ready);
    modport sink   (input valid, input new_mean, input new_variance,
                    input samples_seen, output ready);
endinterface

>>> rtl/welford_vector_variance_update_unit.sv
// ----------------------------------------------------------------------------
// welford_vector_variance_update_unit
// Running per-slot mean and unbiased variance over a stream of vectors.
// ----------------------------------------------------------------------------
// Each transfer in carries one vector element (slot, Q16.16 sample, end flag)
// and gives one transfer out with the slot's new Q16.32 mean, its saturating
// Q32.32 variance and the vector count n. After reset, ready stays low while
// all VECTOR_SLOTS slots (1024 by default) of both stores are swept to zero,
// one slot a cycle. Items are then processed one at a time. The slot is
// reduced to a store address by a reciprocal multiplication; the time is set
// by the shared divider, which retires two quotient bits a cycle over the
// mean step and the two variance divisions by n - 1, and by a 32 x 32
// multiplier that forms each wide product. A finished result waits in an
// output register, and the next item is taken while it waits.
// ----------------------------------------------------------------------------
module welford_vector_variance_update_unit #(
    parameter int VECTOR_SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wvvu_in_if.sink     i_in,
    wvvu_out_if.source  o_out
);
    import wvvu_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing
    wvvu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic and storage
    wvvu_dp #(
        .VECTOR_SLOTS (VECTOR_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_slot         (i_in.slot),
        .i_sample       (i_in.sample),
        .i_vector_end   (i_in.vector_end),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_new_mean     (o_out.new_mean),
        .o_new_variance (o_out.new_variance),
        .o_samples_seen (o_out.samples_seen)
    );

    assign i_in.ready = cmd.in_ready;

endmodule

>>> rtl/wvvu_ram.sv
// ----------------------------------------------------------------------------
// wvvu_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wvvu_ram #(
    parameter  int WIDTH  = 48,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/wvvu_div.sv
// ----------------------------------------------------------------------------
// wvvu_div
// Restoring unsigned divider, two quotient bits per cycle. The dividend comes
// in left aligned; after the given number of steps the quotient sits in the
// low bits of the shift register and the remainder in its own register.
// ----------------------------------------------------------------------------
module wvvu_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [wvvu_pkg::DIV_W-1:0]          i_dividend,
    input  logic [wvvu_pkg::COUNT_W-1:0]        i_divisor,
    input  logic [wvvu_pkg::DIV_STEPS_W-1:0]    i_steps,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [wvvu_pkg::DIV_W-1:0]          o_quot
);
    import wvvu_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_STEPS_W-1:0] r_cnt;
    logic [DIV_W-1:0]       r_dvd;
    logic [COUNT_W-1:0]     r_rem;
    logic [COUNT_W-1:0]     r_dsr;

    logic [DIV_W-1:0]       n_dvd;
    logic [COUNT_W-1:0]     n_rem;
    logic [COUNT_W:0]       trial;
    logic                   qbit;

    // two compare-and-subtract steps per cycle
    always_comb begin
        n_dvd = r_dvd;
        n_rem = r_rem;
        trial = '0;
        qbit  = 1'b0;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_dvd[DIV_W-1]};
            if (trial >= {1'b0, r_dsr}) begin
                trial = trial - {1'b0, r_dsr};
                qbit  = 1'b1;
            end else begin
                qbit  = 1'b0;
            end
            n_rem = trial[COUNT_W-1:0];
            n_dvd = {n_dvd[DIV_W-2:0], qbit};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_STEPS_W'(1);
                if (r_cnt == DIV_STEPS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dvd;

`ifndef SYNTHESIS
    // a finished division leaves a remainder below the divisor
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");
`endif

endmodule

>>> rtl/wvvu_mul.sv
// ----------------------------------------------------------------------------
// wvvu_mul
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier; the four
// partial products are formed one a cycle and summed into a 128-bit
// accumulator on the following cycle.
// ----------------------------------------------------------------------------
module wvvu_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wvvu_pkg::MUL_W-1:0]    i_a,
    input  logic [wvvu_pkg::MUL_W-1:0]    i_b,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [wvvu_pkg::PROD_W-1:0]   o_prod
);
    import wvvu_pkg::*;

    localparam int HALF_W = MUL_W / 2;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_k;
    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic [MUL_W-1:0]  r_pp;
    logic [1:0]        r_sh;
    logic [PROD_W-1:0] r_acc;

    logic [HALF_W-1:0] a_part;
    logic [HALF_W-1:0] b_part;
    logic [MUL_W-1:0]  pp;
    logic [PROD_W-1:0] pp_shifted;

    // partial product selection
    assign a_part     = r_k[1] ? r_a[MUL_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign b_part     = r_k[0] ? r_b[MUL_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign pp         = a_part * b_part;
    assign pp_shifted = PROD_W'(r_pp) << {r_sh, 5'd0};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands, partial product and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_k != 3'd4) begin
                r_pp <= pp;
                r_sh <= {1'b0, r_k[1]} + {1'b0, r_k[0]};
            end
            if (r_k != 3'd0) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

`ifndef SYNTHESIS
    // every start of the multiplier is followed by a done strobe
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##6 r_done)
        else $error("multiplier latency slip");
`endif

endmodule

>>> rtl/wvvu_dp.sv
// ----------------------------------------------------------------------------
// wvvu_dp
// Datapath: slot stores, vector count, shared divider and multiplier, the
// working registers of one update and the output register.
// ----------------------------------------------------------------------------
module wvvu_dp #(
    parameter int VECTOR_SLOTS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wvvu_pkg::t_dp_cmd     i_cmd,
    output wvvu_pkg::t_dp_status  o_status,
    input  wvvu_pkg::t_slot       i_slot,
    input  wvvu_pkg::t_sample     i_sample,
    input  logic                  i_vector_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output wvvu_pkg::t_mean       o_new_mean,
    output wvvu_pkg::t_var        o_new_variance,
    output wvvu_pkg::t_count      o_samples_seen
);
    import wvvu_pkg::*;

    localparam int ADDR_W = (VECTOR_SLOTS > 1) ? $clog2(VECTOR_SLOTS) : 1;

    // slot reduction by reciprocal multiplication, exact for every slot value
    localparam int     RED_L = $clog2(VECTOR_SLOTS);
    localparam int     RED_S = SLOT_W + RED_L;
    localparam longint RED_M = ((longint'(1) << RED_S) + VECTOR_SLOTS - 1) / VECTOR_SLOTS;

    // working registers
    t_sample                r_sample;
    t_slot                  r_slot;
    t_slot                  r_slot_quo;
    logic                   r_last;
    t_count                 r_n;
    t_count                 r_count;
    logic [ADDR_W-1:0]      r_idx;
    logic signed [MEAN_W:0] r_diff;
    t_mean                  r_mean_new;
    logic [T_W-1:0]         r_t;
    logic [NUM_W-1:0]       r_num;
    t_var                   r_var_new;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_out_valid;
    t_mean                  r_out_mean;
    t_var                   r_out_var;
    t_count                 r_out_n;

    // combinational values
    t_mean                  x;
    t_mean                  mean_q;
    t_var                   var_q;
    logic [MEAN_W:0]        abs_diff;
    logic [MEAN_W:0]        mean_q_ext;
    logic [MEAN_W:0]        step;
    logic [MEAN_W:0]        mean_sum;
    t_count                 n_minus_1;
    t_count                 n_minus_2;
    logic [31:0]            slot_prod;
    logic [31:0]            red_rem;

    // arithmetic unit connections
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    t_count                 div_divisor;
    logic [DIV_STEPS_W-1:0] div_steps;
    logic                   div_busy;
    logic                   div_done;
    logic [DIV_W-1:0]       quot;
    logic                   mul_start;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic                   mul_busy;
    logic                   mul_done;
    logic [PROD_W-1:0]      prod;

    // store ports
    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    t_mean                  mean_wr_data;
    t_var                   var_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;

    // sample widened to Q16.32, differences and the signed mean step
    assign x          = {r_sample, {FRAC_EXT{1'b0}}};
    assign abs_diff   = r_diff[MEAN_W] ? (~r_diff + 1'b1) : r_diff;
    assign mean_q_ext = {mean_q[MEAN_W-1], mean_q};
    assign step       = r_diff[MEAN_W] ? (~quot[MEAN_W:0] + 1'b1) : quot[MEAN_W:0];
    assign mean_sum   = mean_q_ext + step;
    assign n_minus_1  = r_n - COUNT_W'(1);
    assign n_minus_2  = r_n - COUNT_W'(2);

    // slot quotient on the way in, remainder in the cycle after
    assign slot_prod  = 32'(i_slot) * 32'(RED_M);
    assign red_rem    = 32'(r_slot) - 32'(r_slot_quo) * 32'(VECTOR_SLOTS);

    // divider operand selection
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = r_n;
        div_steps    = '0;
        case (i_cmd.op)
            OP_MDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(abs_diff) << (DIV_W - MEAN_DIV_BITS);
                div_divisor  = r_n;
                div_steps    = DIV_STEPS_W'(MEAN_DIV_BITS / 2);
            end
            OP_TDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod[T_DIV_BITS-1:0]) << (DIV_W - T_DIV_BITS);
                div_divisor  = n_minus_1;
                div_steps    = DIV_STEPS_W'(T_DIV_BITS / 2);
            end
            OP_VDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_num) << (DIV_W - VAR_DIV_BITS);
                div_divisor  = n_minus_1;
                div_steps    = DIV_STEPS_W'(VAR_DIV_BITS / 2);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (i_cmd.op)
            OP_SQ: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(abs_diff);
                mul_b     = MUL_W'(abs_diff);
            end
            OP_SN: begin
                mul_start = 1'b1;
                mul_a     = prod[95:32];
                mul_b     = MUL_W'(r_n);
            end
            OP_VMUL: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(n_minus_2);
                mul_b     = var_q;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    wvvu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    wvvu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // store access: zero sweep after reset, read at the reduced slot, write back
    assign ram_wr_en    = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_WRITE);
    assign ram_wr_addr  = (i_cmd.op == OP_CLEAR) ? r_clr_addr : r_idx;
    assign mean_wr_data = (i_cmd.op == OP_CLEAR) ? '0 : r_mean_new;
    assign var_wr_data  = (i_cmd.op == OP_CLEAR) ? '0 : r_var_new;
    assign ram_rd_en    = (i_cmd.op == OP_READ);
    assign ram_rd_addr  = red_rem[ADDR_W-1:0];

    wvvu_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (VECTOR_SLOTS)
    ) u_mean_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (mean_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (mean_q)
    );

    wvvu_ram #(
        .WIDTH (VAR_W),
        .DEPTH (VECTOR_SLOTS)
    ) u_var_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (var_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (var_q)
    );

    // control registers: clear sweep, vector count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
                if (r_last && (r_count < COUNT_MAX)) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers of one update
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_sample   <= i_sample;
                r_slot     <= i_slot;
                r_slot_quo <= SLOT_W'(slot_prod >> RED_S);
                r_last     <= i_vector_end;
                r_n        <= r_count + COUNT_W'(1);
            end
            OP_READ: begin
                r_idx <= red_rem[ADDR_W-1:0];
            end
            OP_DIFF: begin
                r_diff <= {x[MEAN_W-1], x} - mean_q_ext;
            end
            OP_MNEW: begin
                r_mean_new <= mean_sum[MEAN_W-1:0];
            end
            OP_ERR: begin
                r_diff <= {x[MEAN_W-1], x} - {r_mean_new[MEAN_W-1], r_mean_new};
            end
            OP_VMUL: begin
                r_t <= quot[T_W-1:0];
            end
            OP_NUM: begin
                r_num <= prod[NUM_W-1:0] + NUM_W'(r_t);
            end
            OP_VNEW: begin
                r_var_new <= (|quot[DIV_W-1:VAR_W]) ? '1 : quot[VAR_W-1:0];
            end
            OP_VKEEP: begin
                r_var_new <= var_q;
            end
            OP_OUT: begin
                r_out_mean <= r_mean_new;
                r_out_var  <= r_var_new;
                r_out_n    <= r_n;
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

    // status back to the controller
    assign o_status.clr_last = (r_clr_addr == ADDR_W'(VECTOR_SLOTS - 1));
    assign o_status.div_done = div_done;
    assign o_status.mul_done = mul_done;
    assign o_status.n_is_one = (r_n == COUNT_W'(1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_new_mean     = r_out_mean;
    assign o_new_variance = r_out_var;
    assign o_samples_seen = r_out_n;

`ifndef SYNTHESIS
    // the shared units are never in use at the same time
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_busy && mul_busy))
        else $error("divider and multiplier busy together");

    // a result appears only through the output load
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == OP_OUT))
        else $error("output valid without load");

    // variance is carried over only for the first vector
    a_keep_first_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_VKEEP) |-> (r_n == COUNT_W'(1)))
        else $error("variance kept with n above one");
`endif

endmodule

>>> rtl/wvvu_ctrl.sv
// ----------------------------------------------------------------------------
// wvvu_ctrl
// Controller: sequences the store sweep after reset and the steps of each
// update through the datapath.
// ----------------------------------------------------------------------------
module wvvu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  wvvu_pkg::t_dp_status  i_status,
    output wvvu_pkg::t_dp_cmd     o_cmd
);
    import wvvu_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_status.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid)        n_state = S_MOD;
            S_MOD:   n_state = S_DIFF;
            S_DIFF:  n_state = S_MDIV;
            S_MDIV:  n_state = S_MWAIT;
            S_MWAIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.n_is_one ? S_VKEEP : S_ERR;
                end
            end
            S_ERR:   n_state = S_SQ;
            S_SQ:    n_state = S_SQW;
            S_SQW:   if (i_status.mul_done) n_state = S_SNW;
            S_SNW:   if (i_status.mul_done) n_state = S_TDW;
            S_TDW:   if (i_status.div_done) n_state = S_VMW;
            S_VMW:   if (i_status.mul_done) n_state = S_NUM;
            S_NUM:   n_state = S_VDIV;
            S_VDIV:  n_state = S_VDW;
            S_VDW:   if (i_status.div_done) n_state = S_WRITE;
            S_VKEEP: n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.op = OP_CLEAR;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_ACCEPT;
            end
            S_MOD:   o_cmd.op = OP_READ;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_MDIV:  o_cmd.op = OP_MDIV;
            S_MWAIT: if (i_status.div_done) o_cmd.op = OP_MNEW;
            S_ERR:   o_cmd.op = OP_ERR;
            S_SQ:    o_cmd.op = OP_SQ;
            S_SQW:   if (i_status.mul_done) o_cmd.op = OP_SN;
            S_SNW:   if (i_status.mul_done) o_cmd.op = OP_TDIV;
            S_TDW:   if (i_status.div_done) o_cmd.op = OP_VMUL;
            S_VMW:   if (i_status.mul_done) o_cmd.op = OP_NUM;
            S_NUM:   o_cmd.op = OP_NONE;
            S_VDIV:  o_cmd.op = OP_VDIV;
            S_VDW:   if (i_status.div_done) o_cmd.op = OP_VNEW;
            S_VKEEP: o_cmd.op = OP_VKEEP;
            S_WRITE: o_cmd.op = OP_WRITE;
            S_OUT:   if (i_status.out_free) o_cmd.op = OP_OUT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule
